FILE: rtl/emc_pkg.sv
`timescale 1ns / 1ps
package emc_pkg;

   localparam int ID_W      = 10;
   localparam int POS_W     = 24;
   localparam int RAD_W     = 23;
   localparam int NID_CSR_W = 11;
   localparam int CSR_IDX_W = 3;
   localparam int ROOT_W    = 31;
   localparam int QUO_W     = 24;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_NEW_ID = 3'd4;

   localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd4096;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_CREATED   = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_EXHAUSTED = 2'd3
   } status_type;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct packed {
      logic            func;
      logic [ID_W-1:0] lo;
      logic [ID_W-1:0] hi;
      pos_type         mx;
      pos_type         my;
      pos_type         mz;
      logic            bnd;
   } item_type;

   typedef enum logic [2:0] {
      B_SWEEP,
      B_IDLE,
      B_LOOKUP,
      B_FILL,
      B_SCAN,
      B_DECIDE,
      B_GEOM,
      B_WAIT
   } back_state_type;

   typedef enum logic [2:0] {
      G_IDLE,
      G_SQUARE,
      G_ROOT,
      G_SCALE,
      G_LOAD,
      G_DIVIDE,
      G_PLACE,
      G_DONE
   } geom_state_type;

endpackage

FILE: rtl/emc_front.sv
`timescale 1ns / 1ps
module emc_front (
   input  logic                          req_func,
   input  logic [emc_pkg::ID_W-1:0]      req_first_id,
   input  logic [emc_pkg::ID_W-1:0]      req_second_id,
   input  emc_pkg::pos_type              req_first_x,
   input  emc_pkg::pos_type              req_first_y,
   input  emc_pkg::pos_type              req_first_z,
   input  emc_pkg::pos_type              req_second_x,
   input  emc_pkg::pos_type              req_second_y,
   input  emc_pkg::pos_type              req_second_z,
   input  logic                          req_first_on_boundary,
   input  logic                          req_second_on_boundary,
   output emc_pkg::item_type             item_out
);
   import emc_pkg::*;

   // floor of the mean, arithmetic shift of the 25-bit sum
   function automatic pos_type mean2(pos_type a, pos_type b);
      logic signed [POS_W:0] s;
      s = {a[POS_W-1], a} + {b[POS_W-1], b};
      return s[POS_W:1];
   endfunction

   logic first_lower;

   assign first_lower = (req_first_id < req_second_id);

   always_comb begin
      item_out.func = req_func;
      item_out.lo   = first_lower ? req_first_id : req_second_id;
      item_out.hi   = first_lower ? req_second_id : req_first_id;
      item_out.mx   = mean2(req_first_x, req_second_x);
      item_out.my   = mean2(req_first_y, req_second_y);
      item_out.mz   = mean2(req_first_z, req_second_z);
      item_out.bnd  = req_first_on_boundary & req_second_on_boundary;
   end

endmodule

FILE: rtl/emc_queue.sv
`timescale 1ns / 1ps
module emc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  emc_pkg::item_type item_in,
   input  logic              rd_en,
   output emc_pkg::item_type item_out,
   output logic              full,
   output logic              empty
);
   import emc_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign item_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

FILE: rtl/emc_geom.sv
`timescale 1ns / 1ps
module emc_geom (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  emc_pkg::pos_type           mean_in   [3],
   input  emc_pkg::pos_type           center_in [3],
   input  logic [emc_pkg::RAD_W-1:0]  radius_in,
   output logic                       done,
   output emc_pkg::pos_type           pos_out   [3]
);
   import emc_pkg::*;

   localparam int PROD_W = 2 * POS_W;
   localparam int NUM_W  = 2 * ROOT_W;
   localparam int DIVN_W = PROD_W - 1 + 8;

   geom_state_type state_ff, state_in;

   logic [POS_W-1:0]    mag_ff [3];
   logic [2:0]          neg_ff;
   logic [1:0]          axis_ff;
   logic [4:0]          cnt_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   acc_ff;
   logic [NUM_W-1:0]    sq_num_ff;
   logic [ROOT_W:0]     sq_rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [ROOT_W:0]     div_rem_ff;
   logic [QUO_W-1:0]    quo_ff;
   pos_type             pos_ff [3];

   logic [1:0]          sel;
   logic                square_phase;
   logic [POS_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic [PROD_W-1:0]   acc_in;
   logic [ROOT_W+2:0]   rem_sh, trial;
   logic                root_bit;
   logic [DIVN_W-1:0]   div_num;
   logic [ROOT_W+1:0]   rem2, divisor;
   logic                quo_bit;
   logic [QUO_W-1:0]    q_eff;
   logic signed [QUO_W:0]   off;
   logic signed [POS_W+1:0] sum;
   pos_type             placed;

   // one shared unsigned multiplier: |m| * |m| or radius * |m|
   assign square_phase = (state_ff == G_SQUARE);
   assign sel   = square_phase ? ((cnt_ff[1:0] == 2'd3) ? 2'd0 : cnt_ff[1:0]) : axis_ff;
   assign mul_a = mag_ff[sel];
   assign mul_b = square_phase ? mag_ff[sel] : {1'b0, radius_in};
   assign mul_p = mul_a * mul_b;
   assign acc_in = acc_ff + ((cnt_ff == 5'd0) ? '0 : prod_ff);

   // one root bit per cycle, two radicand bits consumed
   assign rem_sh   = {sq_rem_ff, sq_num_ff[NUM_W-1 -: 2]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign root_bit = (rem_sh >= trial);

   // rounded quotient (2num + L) / 2L, one quotient bit per cycle
   assign div_num = {prod_ff[PROD_W-2:0], 8'b0} + DIVN_W'(root_ff);
   assign divisor = {1'b0, root_ff, 1'b0};
   assign rem2    = {div_rem_ff, quo_ff[QUO_W-1]};
   assign quo_bit = (rem2 >= divisor);

   assign q_eff = (root_ff == '0) ? '0 : quo_ff;
   assign off   = neg_ff[axis_ff] ? -$signed({1'b0, q_eff}) : $signed({1'b0, q_eff});
   assign sum   = {{2{center_in[axis_ff][POS_W-1]}}, center_in[axis_ff]}
                + {off[QUO_W], off};

   always_comb begin
      if (sum > $signed(26'sd8388607)) begin
         placed = 24'sh7FFFFF;
      end else if (sum < -$signed(26'sd8388608)) begin
         placed = 24'sh800000;
      end else begin
         placed = sum[POS_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         G_IDLE:   if (start) state_in = G_SQUARE;
         G_SQUARE: if (cnt_ff == 5'd3) state_in = G_ROOT;
         G_ROOT:   if (cnt_ff == 5'(ROOT_W - 1)) state_in = G_SCALE;
         G_SCALE:  state_in = G_LOAD;
         G_LOAD:   state_in = G_DIVIDE;
         G_DIVIDE: if (cnt_ff == 5'(QUO_W - 1)) state_in = G_PLACE;
         G_PLACE:  state_in = (axis_ff == 2'd2) ? G_DONE : G_SCALE;
         G_DONE:   state_in = G_IDLE;
         default:  state_in = G_IDLE;
      endcase
   end

   always_comb begin
      done       = (state_ff == G_DONE);
      pos_out[0] = pos_ff[0];
      pos_out[1] = pos_ff[1];
      pos_out[2] = pos_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         G_IDLE: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= mean_in[i][POS_W-1] ? POS_W'(-mean_in[i]) : POS_W'(mean_in[i]);
               neg_ff[i] <= mean_in[i][POS_W-1];
            end
            cnt_ff  <= '0;
            acc_ff  <= '0;
            axis_ff <= '0;
         end
         G_SQUARE: begin
            prod_ff <= mul_p;
            acc_ff  <= acc_in;
            if (cnt_ff == 5'd3) begin
               sq_num_ff <= {acc_in[NUM_W-15:0], 14'b0};
               sq_rem_ff <= '0;
               root_ff   <= '0;
               cnt_ff    <= '0;
            end else begin
               cnt_ff <= cnt_ff + 5'd1;
            end
         end
         G_ROOT: begin
            sq_num_ff <= {sq_num_ff[NUM_W-3:0], 2'b00};
            if (root_bit) begin
               sq_rem_ff <= (ROOT_W + 1)'(rem_sh - trial);
               root_ff   <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               sq_rem_ff <= rem_sh[ROOT_W:0];
               root_ff   <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
         end
         G_SCALE: begin
            prod_ff <= mul_p;
         end
         G_LOAD: begin
            div_rem_ff <= (ROOT_W + 1)'(div_num[DIVN_W-1:QUO_W]);
            quo_ff     <= div_num[QUO_W-1:0];
            cnt_ff     <= '0;
         end
         G_DIVIDE: begin
            if (quo_bit) begin
               div_rem_ff <= (ROOT_W + 1)'(rem2 - divisor);
            end else begin
               div_rem_ff <= rem2[ROOT_W:0];
            end
            quo_ff <= {quo_ff[QUO_W-2:0], quo_bit};
            cnt_ff <= cnt_ff + 5'd1;
         end
         G_PLACE: begin
            pos_ff[axis_ff] <= placed;
            axis_ff         <= axis_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/emc_back.sv
`timescale 1ns / 1ps
module emc_back #(
   parameter int MAX_NODES      = 1024,
   parameter int EDGES_PER_NODE = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  emc_pkg::item_type                 q_item,
   output logic                              q_pop,
   output logic                              init_busy,
   input  logic                              csr_valid,
   input  logic [emc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [emc_pkg::POS_W-1:0]         csr_data,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output logic [emc_pkg::ID_W-1:0]          rsp_mid_id,
   output emc_pkg::pos_type                  rsp_mid_x,
   output emc_pkg::pos_type                  rsp_mid_y,
   output emc_pkg::pos_type                  rsp_mid_z,
   output logic                              rsp_mid_on_boundary,
   output logic [1:0]                        rsp_status
);
   import emc_pkg::*;

   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int ENT_DEPTH = MAX_NODES * EDGES_PER_NODE;
   localparam int ENT_W     = $clog2(ENT_DEPTH);
   localparam int FILL_W    = $clog2(EDGES_PER_NODE + 1);
   localparam int NID_W     = ($clog2(MAX_NODES + 1) > NID_CSR_W) ?
                              $clog2(MAX_NODES + 1) : NID_CSR_W;
   localparam int ENT_DW    = 2 * ID_W;

   back_state_type state_ff, state_in;

   item_type            cur_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   k_ff;
   logic [NODE_W-1:0]   sweep_ff;
   logic                init_busy_ff;
   logic [NID_W-1:0]    next_id_ff;
   pos_type             center_ff [3];
   logic [RAD_W-1:0]    radius_ff;
   status_type          status_ff;
   logic [ID_W-1:0]     id_ff;
   logic                out_valid_ff;
   logic [ID_W-1:0]     out_id_ff;
   pos_type             out_pos_ff [3];
   logic                out_bnd_ff;
   status_type          out_status_ff;

   logic [FILL_W-1:0]   fill_mem [MAX_NODES];
   logic [ENT_DW-1:0]   ent_mem  [ENT_DEPTH];
   logic [FILL_W-1:0]   fill_rd_ff;
   logic [ENT_DW-1:0]   ent_rd_ff;

   logic                lo_out_range;
   logic [NODE_W-1:0]   lo_idx;
   logic [ENT_W-1:0]    base;
   logic [FILL_W-1:0]   k_next;
   logic [FILL_W-1:0]   k_sel;
   logic [ENT_W-1:0]    ent_rd_addr;
   logic                ent_hit;
   logic                sweep_last;
   logic                exhausted;
   logic                bucket_full;
   logic                create;
   logic                fill_we;
   logic [NODE_W-1:0]   fill_wa;
   logic [FILL_W-1:0]   fill_wd;
   logic                ent_we;
   logic                geom_start;
   logic                geom_done;
   pos_type             geom_pos [3];
   pos_type             cur_mean [3];
   logic                out_load;

   function automatic logic [FILL_W-1:0] k_fill_inc(logic [FILL_W-1:0] f);
      return f + 1'b1;
   endfunction

   assign lo_out_range = (32'(cur_ff.lo) >= MAX_NODES);
   assign lo_idx       = NODE_W'(cur_ff.lo);
   assign base         = ENT_W'(int'(lo_idx) * EDGES_PER_NODE);
   assign k_next       = k_ff + 1'b1;
   assign k_sel        = (state_ff == B_FILL) ? '0 : k_next;
   assign ent_rd_addr  = base + ENT_W'(k_sel);
   assign ent_hit      = (ent_rd_ff[ID_W-1:0] == cur_ff.hi);
   assign sweep_last   = (sweep_ff == NODE_W'(MAX_NODES - 1));
   assign exhausted    = (32'(next_id_ff) >= MAX_NODES);
   assign bucket_full  = (fill_ff == FILL_W'(EDGES_PER_NODE));
   assign create       = (state_ff == B_DECIDE) && !bucket_full && !exhausted;

   assign cur_mean[0] = cur_ff.mx;
   assign cur_mean[1] = cur_ff.my;
   assign cur_mean[2] = cur_ff.mz;

   emc_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .start     (geom_start),
      .mean_in   (cur_mean),
      .center_in (center_ff),
      .radius_in (radius_ff),
      .done      (geom_done),
      .pos_out   (geom_pos)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_SWEEP: begin
            if (sweep_last) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (!q_empty && !out_valid_ff) begin
               state_in = (q_item.func == FUNC_CLEAR) ? B_SWEEP : B_LOOKUP;
            end
         end
         B_LOOKUP: state_in = lo_out_range ? B_GEOM : B_FILL;
         B_FILL:   state_in = (fill_rd_ff == '0) ? B_DECIDE : B_SCAN;
         B_SCAN: begin
            if (ent_hit) begin
               state_in = B_GEOM;
            end else if (k_next == fill_ff) begin
               state_in = B_DECIDE;
            end
         end
         B_DECIDE: state_in = B_GEOM;
         B_GEOM:   state_in = cur_ff.bnd ? B_WAIT : B_IDLE;
         B_WAIT: begin
            if (geom_done) state_in = B_IDLE;
         end
         default:  state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = (state_ff == B_IDLE) && !q_empty && !out_valid_ff;
      geom_start = (state_ff == B_GEOM) && cur_ff.bnd;
      out_load   = ((state_ff == B_GEOM) && !cur_ff.bnd) ||
                   ((state_ff == B_WAIT) && geom_done);
      fill_we    = (state_ff == B_SWEEP) || create;
      fill_wa    = (state_ff == B_SWEEP) ? sweep_ff : lo_idx;
      fill_wd    = (state_ff == B_SWEEP) ? '0 : k_fill_inc(fill_ff);
      ent_we     = create;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_SWEEP;
         sweep_ff     <= '0;
         init_busy_ff <= 1'b1;
         out_valid_ff <= 1'b0;
         next_id_ff   <= '0;
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         radius_ff    <= RADIUS_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_SWEEP) begin
            sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
            if (sweep_last) init_busy_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_CENTER_X:     center_ff[0] <= csr_data;
               CSR_CENTER_Y:     center_ff[1] <= csr_data;
               CSR_CENTER_Z:     center_ff[2] <= csr_data;
               CSR_RADIUS:       radius_ff    <= csr_data[RAD_W-1:0];
               CSR_FIRST_NEW_ID: next_id_ff   <= NID_W'(csr_data[NID_CSR_W-1:0]);
               default: begin
               end
            endcase
         end else if (create) begin
            next_id_ff <= next_id_ff + 1'b1;
         end
      end
   end

   // transaction payload and search bookkeeping
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
      end
      case (state_ff)
         B_LOOKUP: begin
            status_ff <= STATUS_FULL;
            id_ff     <= '0;
         end
         B_FILL: begin
            fill_ff <= fill_rd_ff;
            k_ff    <= '0;
         end
         B_SCAN: begin
            k_ff <= k_next;
            if (ent_hit) begin
               status_ff <= STATUS_FOUND;
               id_ff     <= ent_rd_ff[ENT_DW-1:ID_W];
            end
         end
         B_DECIDE: begin
            if (bucket_full) begin
               status_ff <= STATUS_FULL;
            end else if (exhausted) begin
               status_ff <= STATUS_EXHAUSTED;
            end else begin
               status_ff <= STATUS_CREATED;
               id_ff     <= next_id_ff[ID_W-1:0];
            end
         end
         default: begin
         end
      endcase
      if (out_load) begin
         out_id_ff     <= id_ff;
         out_bnd_ff    <= cur_ff.bnd;
         out_status_ff <= status_ff;
         for (int i = 0; i < 3; i++) begin
            out_pos_ff[i] <= cur_ff.bnd ? geom_pos[i] : cur_mean[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_wa] <= fill_wd;
      end
      fill_rd_ff <= fill_mem[lo_idx];
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[base + ENT_W'(fill_ff)] <= {next_id_ff[ID_W-1:0], cur_ff.hi};
      end
      ent_rd_ff <= ent_mem[ent_rd_addr];
   end

   assign init_busy           = init_busy_ff;
   assign rsp_empty           = !out_valid_ff;
   assign rsp_mid_id          = out_id_ff;
   assign rsp_mid_x           = out_pos_ff[0];
   assign rsp_mid_y           = out_pos_ff[1];
   assign rsp_mid_z           = out_pos_ff[2];
   assign rsp_mid_on_boundary = out_bnd_ff;
   assign rsp_status          = out_status_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> (fill_wd <= FILL_W'(EDGES_PER_NODE)))
      else $error("bucket fill written beyond bucket size");

   a_id_advance: assert property (@(posedge clock) disable iff (reset)
      (create && !csr_valid) |=> (next_id_ff == $past(next_id_ff) + 1'b1))
      else $error("id counter did not advance on create");

   a_wait_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WAIT) |-> !out_valid_ff)
      else $error("geometry running while result slot occupied");

   a_no_pop_init: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !init_busy_ff)
      else $error("transaction taken during table init");

endmodule

FILE: rtl/edge_midpoint_cache_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// req       in         push / full                func, ids, positions, boundary flags
// rsp       out        pop / empty                mid_id, mid_x/y/z, mid_on_boundary, status
// csr       in         csr_valid / csr_ready      csr_index, csr_data
//
// add: the bucket of the lower id is read and up to EDGES_PER_NODE entries scanned; a
// boundary edge also runs the shared square-root and divider unit (31 root steps,
// 24 quotient steps per axis). clear: one bucket count cleared a cycle, MAX_NODES in all.
// after reset all MAX_NODES bucket counts are cleared while full stays high.
// a two-entry queue decouples intake from the table engine; a held result stalls the engine.
module edge_midpoint_cache_unit #(
   parameter int MAX_NODES      = 1024,
   parameter int EDGES_PER_NODE = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic                           req_func,
   input  logic [emc_pkg::ID_W-1:0]       req_first_id,
   input  logic [emc_pkg::ID_W-1:0]       req_second_id,
   input  emc_pkg::pos_type               req_first_x,
   input  emc_pkg::pos_type               req_first_y,
   input  emc_pkg::pos_type               req_first_z,
   input  emc_pkg::pos_type               req_second_x,
   input  emc_pkg::pos_type               req_second_y,
   input  emc_pkg::pos_type               req_second_z,
   input  logic                           req_first_on_boundary,
   input  logic                           req_second_on_boundary,
   input  logic                           pop,
   output logic                           empty,
   output logic [emc_pkg::ID_W-1:0]       rsp_mid_id,
   output emc_pkg::pos_type               rsp_mid_x,
   output emc_pkg::pos_type               rsp_mid_y,
   output emc_pkg::pos_type               rsp_mid_z,
   output logic                           rsp_mid_on_boundary,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [emc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [emc_pkg::POS_W-1:0]      csr_data
);
   import emc_pkg::*;

   item_type front_item;
   item_type q_item;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;
   logic     init_busy;
   logic     q_push;

   assign full      = q_full || init_busy;
   assign q_push    = push && !full;
   assign csr_ready = 1'b1;

   emc_front u_front (
      .req_func               (req_func),
      .req_first_id           (req_first_id),
      .req_second_id          (req_second_id),
      .req_first_x            (req_first_x),
      .req_first_y            (req_first_y),
      .req_first_z            (req_first_z),
      .req_second_x           (req_second_x),
      .req_second_y           (req_second_y),
      .req_second_z           (req_second_z),
      .req_first_on_boundary  (req_first_on_boundary),
      .req_second_on_boundary (req_second_on_boundary),
      .item_out               (front_item)
   );

   emc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .item_in  (front_item),
      .rd_en    (q_pop),
      .item_out (q_item),
      .full     (q_full),
      .empty    (q_empty)
   );

   emc_back #(
      .MAX_NODES      (MAX_NODES),
      .EDGES_PER_NODE (EDGES_PER_NODE)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .init_busy           (init_busy),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_pop             (pop),
      .rsp_empty           (empty),
      .rsp_mid_id          (rsp_mid_id),
      .rsp_mid_x           (rsp_mid_x),
      .rsp_mid_y           (rsp_mid_y),
      .rsp_mid_z           (rsp_mid_z),
      .rsp_mid_on_boundary (rsp_mid_on_boundary),
      .rsp_status          (rsp_status)
   );

endmodule
